/* sv/sdcd_pkg.sv */
`timescale 1ns / 1ps

package sdcd_pkg;

    localparam logic [31:0] OSC_HZ       = 32'd24000000;
    localparam logic [31:0] BAND_SLOW_HZ = 32'd400000;
    localparam logic [31:0] BAND_MID_HZ  = 32'd25000000;
    localparam logic [31:0] BAND_FAST_HZ = 32'd50000000;
    localparam logic [31:0] PLL_RESET_HZ = 32'd600000000;
    localparam logic [31:0] DIV_MAX      = 32'd16;
    localparam logic [1:0]  MAX_HALVINGS = 2'd3;

    localparam int unsigned ENABLE_POS = 31;
    localparam int unsigned SOURCE_POS = 24;

    typedef logic [1:0] status_t;

    localparam status_t ST_SET         = 2'd0;
    localparam status_t ST_STOPPED     = 2'd1;
    localparam status_t ST_UNREACHABLE = 2'd2;

    // (output delay, sample delay) pair of one frequency band
    typedef struct packed {
        logic [2:0] odly;
        logic [2:0] sdly;
    } delay_t;

endpackage

/* sv/sd_clock_divider_solver_top.sv */
`timescale 1ns / 1ps

// SD card clock divider solver.
// Command channel: drive target_hz with start high; the word is taken at the
// clock edge where start is high and busy is low. A zero target is answered
// on the next cycle. Any other target runs a bit-serial division of the
// source frequency (24 MHz oscillator up to 24 MHz, else the PLL register)
// by the target, one quotient bit per cycle, then rounds the quotient up,
// then halves it once per prescaler step (at most three halvings) and at
// last packs the word or reports it unreachable. One item is worked at a
// time.
// Result channel: clock_word and status are shown for exactly one cycle with
// done high; the receiver cannot stall and must take the word there.
// Configuration: APB write to byte address 0 sets pll_frequency_hz; pready
// is tied high. Write it only while busy is low and no result is pending.
// Reset: the held clock word clears to zero, the PLL register returns to
// 600 MHz and the solver goes idle with done low.
module sd_clock_divider_solver_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          target_hz,
    output logic                 done,
    output logic [31:0]          clock_word,
    output sdcd_pkg::status_t    status,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import sdcd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_CEIL = 2'd2;
    localparam logic [1:0] S_NORM = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [31:0] pll_reg, pll_next;
    logic [31:0] word_reg, word_next;
    logic        done_reg, done_next;
    status_t     status_reg, status_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        pll_src_reg, pll_src_next;
    logic [1:0]  halv_reg, halv_next;

    logic        accept;
    logic        cfg_wr;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] inc_sum;
    delay_t      dly;

    assign pready = 1'b1;
    assign accept = start && (state_reg == S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? pll_reg : 32'd0;

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign clock_word = word_reg;
    assign status     = status_reg;

    // Shift the next dividend bit into the partial remainder, trial subtract
    assign rem_sh  = {rem_reg[31:0], quo_reg[31]};
    assign ge      = (rem_sh >= {1'b0, dsr_reg});
    assign inc_sum = {1'b0, quo_reg} + 33'd1;

    // Delay band from the target held in the divisor register
    always_comb
    begin
        priority if (dsr_reg <= BAND_SLOW_HZ)
        begin
            dly = '{odly: 3'd0, sdly: 3'd0};
        end
        else if (dsr_reg <= BAND_MID_HZ)
        begin
            dly = '{odly: 3'd0, sdly: 3'd5};
        end
        else if (dsr_reg <= BAND_FAST_HZ)
        begin
            dly = '{odly: 3'd3, sdly: 3'd4};
        end
        else
        begin
            dly = '{odly: 3'd1, sdly: 3'd4};
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pll_next     = cfg_wr ? pwdata : pll_reg;
        word_next    = word_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dsr_next     = dsr_reg;
        cnt_next     = cnt_reg;
        pll_src_next = pll_src_reg;
        halv_next    = halv_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (target_hz == 32'd0)
                    begin
                        // Stop the clock: drop only the enable bit
                        word_next             = word_reg;
                        word_next[ENABLE_POS] = 1'b0;
                        status_next           = ST_STOPPED;
                        done_next             = 1'b1;
                    end
                    else
                    begin
                        pll_src_next = (target_hz > OSC_HZ);
                        quo_next     = (target_hz > OSC_HZ) ? pll_reg : OSC_HZ;
                        dsr_next     = target_hz;
                        rem_next     = 33'd0;
                        cnt_next     = 5'd31;
                        halv_next    = 2'd0;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
                quo_next = {quo_reg[30:0], ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_CEIL;
                end
            end
            S_CEIL:
            begin
                // Round up; a zero quotient means the fastest setting
                if (quo_reg == 32'd0)
                begin
                    quo_next = 32'd1;
                end
                else if (rem_reg != 33'd0)
                begin
                    quo_next = inc_sum[31:0];
                end
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (quo_reg > DIV_MAX)
                begin
                    if (halv_reg == MAX_HALVINGS)
                    begin
                        status_next = ST_UNREACHABLE;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        quo_next  = inc_sum[32:1];
                        halv_next = halv_reg + 2'd1;
                    end
                end
                else
                begin
                    word_next             = 32'd0;
                    word_next[ENABLE_POS] = 1'b1;
                    word_next[SOURCE_POS] = pll_src_reg;
                    word_next[22:20]      = dly.sdly;
                    word_next[17:16]      = halv_reg;
                    word_next[10:8]       = dly.odly;
                    word_next[3:0]        = quo_reg[3:0] - 4'd1;
                    status_next           = ST_SET;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pll_reg    <= PLL_RESET_HZ;
            word_reg   <= 32'd0;
            done_reg   <= 1'b0;
            status_reg <= ST_SET;
        end
        else
        begin
            state_reg  <= state_next;
            pll_reg    <= pll_next;
            word_reg   <= word_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dsr_reg     <= dsr_next;
        cnt_reg     <= cnt_next;
        pll_src_reg <= pll_src_next;
        halv_reg    <= halv_next;
    end

endmodule

/* sv/sdcd_checker.sv */
`timescale 1ns / 1ps

module sdcd_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [31:0]       target_hz,
    input  logic              done,
    input  logic [31:0]       clock_word,
    input  sdcd_pkg::status_t status
);
    import sdcd_pkg::*;

    // A result only ever lands once the solver has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A zero target is answered at once with the clock stopped
    a_stop_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (target_hz == 32'd0)) |=>
            (done && (status == ST_STOPPED) && !clock_word[ENABLE_POS]))
        else $error("stop request not answered next cycle");

    // A non-zero target starts the serial divider
    a_work: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (target_hz != 32'd0)) |=> (busy && !done))
        else $error("non-zero target did not start work");

    // A clock that was set is enabled
    a_set_en: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_SET)) |-> clock_word[ENABLE_POS])
        else $error("set clock without enable");

    // An unreachable target keeps the word held before
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_UNREACHABLE)) |-> $stable(clock_word))
        else $error("unreachable target changed the word");

endmodule

bind sd_clock_divider_solver_top sdcd_checker u_sdcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .target_hz  (target_hz),
    .done       (done),
    .clock_word (clock_word),
    .status     (status)
);

/* sim/sd_clock_divider_solver_top_tb.sv */
`timescale 1ns / 1ps

module sd_clock_divider_solver_top_tb;

    import sdcd_pkg::*;

    // Register map: pll_frequency_hz is the only register, at byte address 0.
    localparam logic [2:0] PLL_FREQ_ADDR = 3'd0;

    // Passed as the gap of send_target: keep start high for a word that follows.
    localparam int KEEP_START = -1;

    // Allow a margin once the last word is home.
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [31:0] clock_word;
        status_t     status;
    } solved_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] target_hz = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        done;
    logic [31:0] clock_word;
    status_t     status;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the block's register and held clock word.
    logic [31:0] model_pll_hz;
    logic [31:0] model_held_word;

    // Words the solver still owes us, oldest first.
    solved_word_t pending_words[$];
    int           fault_count = 0;

    sd_clock_divider_solver_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .target_hz (target_hz),
        .done      (done),
        .clock_word(clock_word),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    // Work out the clock word and status for one target and advance the
    // shadow held word exactly as the solver should.
    function automatic void solve_clock_word(input logic [31:0] tgt,
                                             output logic [31:0] word,
                                             output status_t st);
        logic [31:0] src_hz;
        logic        src_pll;
        logic [63:0] divider;
        int          halvings;
        logic [2:0]  odly;
        logic [2:0]  sdly;
        if (tgt == 32'd0) begin
            // Stop the clock: drop only the enable, keep the rest of the word.
            model_held_word[ENABLE_POS] = 1'b0;
            st = ST_STOPPED;
        end
        else begin
            // Oscillator up to 24 MHz inclusive, PLL above.
            if (tgt <= OSC_HZ) begin
                src_hz  = OSC_HZ;
                src_pll = 1'b0;
            end
            else begin
                src_hz  = model_pll_hz;
                src_pll = 1'b1;
            end
            // Ceiling division; a zero PLL gives zero, which means divide by one.
            divider = {32'd0, src_hz / tgt};
            if ((src_hz % tgt) != 32'd0)
                divider = divider + 64'd1;
            if (divider == 64'd0)
                divider = 64'd1;
            halvings = 0;
            while (divider > {32'd0, DIV_MAX}) begin
                halvings++;
                divider = (divider + 64'd1) >> 1;
            end
            if (halvings > int'(MAX_HALVINGS)) begin
                // Out of range: hold the word as it was.
                st = ST_UNREACHABLE;
            end
            else begin
                if (tgt <= BAND_SLOW_HZ) begin
                    odly = 3'd0;
                    sdly = 3'd0;
                end
                else if (tgt <= BAND_MID_HZ) begin
                    odly = 3'd0;
                    sdly = 3'd5;
                end
                else if (tgt <= BAND_FAST_HZ) begin
                    odly = 3'd3;
                    sdly = 3'd4;
                end
                else begin
                    odly = 3'd1;
                    sdly = 3'd4;
                end
                model_held_word             = '0;
                model_held_word[ENABLE_POS] = 1'b1;
                model_held_word[SOURCE_POS] = src_pll;
                model_held_word[22:20]      = sdly;
                model_held_word[17:16]      = halvings[1:0];
                model_held_word[10:8]       = odly;
                model_held_word[3:0]        = divider[3:0] - 4'd1;
                st = ST_SET;
            end
        end
        word = model_held_word;
    endfunction

    // Offer one target word and wait for the solver to take it. Call at a
    // rising edge. A gap of KEEP_START leaves start high for the next word;
    // any other gap drops start and idles for the length of the gap.
    task automatic send_target(input logic [31:0] tgt, input int gap);
        solved_word_t expected;
        start     <= 1'b1;
        target_hz <= tgt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        solve_clock_word(tgt, expected.clock_word, expected.status);
        pending_words.push_back(expected);
        if (gap != KEEP_START) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Reprogram the PLL frequency. Only legal with the solver idle, so drain
    // every owed word first, then run one APB setup and access phase.
    task automatic write_pll_frequency(input logic [31:0] value);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PLL_FREQ_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // pready is tied high, so the register loads at this edge.
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        model_pll_hz  = value;
        @(posedge clk);
    endtask

    // Result checker: the solver cannot be stalled, so take every word at the
    // edge that ends its done cycle and compare with the oldest owed word.
    always @(posedge clk) begin
        solved_word_t expected;
        if (rst_n && done) begin
            if (pending_words.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected word: clock_word=%h status=%0d",
                             clock_word, status);
            end
            else begin
                expected = pending_words.pop_front();
                if (clock_word !== expected.clock_word || status !== expected.status) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: clock_word exp %h got %h, status exp %0d got %0d",
                                 expected.clock_word, clock_word, expected.status, status);
                end
            end
        end
    end

    // Directed targets at the reset PLL frequency: band edges, the divide
    // limits of each prescaler step, stop requests and targets above source.
    task automatic test_band_edges();
        logic [31:0] targets[$];
        targets = '{32'd0,          // stop with nothing programmed yet
                    32'd1,          // far too slow: unreachable
                    32'd400000, 32'd400001,
                    32'd100000,     // needs four halvings: unreachable
                    32'd187500,     // exactly 128: three halvings
                    32'd187499,     // just past the prescaler range
                    32'd1500000,    // divide by exactly sixteen
                    32'd1411764,    // divide by eighteen: one halving
                    32'd0,          // stop, keep the rest of the word
                    32'd24000000, 32'd24000001,
                    32'd25000000, 32'd25000001,
                    32'd50000000, 32'd50000001,
                    32'd600000000,
                    32'd600000001,  // above the source: divide by one
                    32'hFFFFFFFF,
                    32'd0};
        foreach (targets[i])
            send_target(targets[i], (i == targets.size() - 1) ? 0 : KEEP_START);
    endtask

    // PLL register extremes: zero (division gives zero), one, and all ones.
    task automatic test_pll_extremes();
        logic [31:0] plls[$];
        logic [31:0] targets[$];
        plls    = '{32'd0, 32'd1, 32'hFFFFFFFF};
        targets = '{32'd24000001, 32'd300000000, 32'd50000000, 32'hFFFFFFFF,
                    32'd0, 32'd12000000};
        foreach (plls[p]) begin
            write_pll_frequency(plls[p]);
            foreach (targets[i])
                send_target(targets[i], (i == targets.size() - 1) ? 0 : KEEP_START);
        end
        write_pll_frequency(PLL_RESET_HZ);
    endtask

    // Random targets under one PLL setting, weighted across the bands and
    // their edges, with random idle bursts on the command side if asked.
    task automatic test_random_targets(input int count, input logic [31:0] pll,
                                       input bit with_idle);
        logic [31:0] tgt;
        logic [31:0] edges[$];
        int          gap;
        write_pll_frequency(pll);
        edges = '{BAND_SLOW_HZ, BAND_MID_HZ, BAND_FAST_HZ, OSC_HZ,
                  32'd187500, 32'd1500000, pll, pll >> 4, pll >> 7};
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0:           tgt = 32'd0;
                1, 2, 3:     tgt = $urandom_range(1, 400000);
                4, 5, 6:     tgt = $urandom_range(400001, 25000000);
                7, 8:        tgt = $urandom_range(25000001, 50000000);
                9, 10:       tgt = $urandom_range(50000001, 32'hFFFFFFFF);
                11, 12, 13:  tgt = edges[$urandom_range(0, edges.size() - 1)]
                                   + $urandom_range(0, 4) - 32'd2;
                14, 15, 16:  tgt = $urandom;
                default:     tgt = $urandom_range(1, 2000000);
            endcase
            // Idle in random bursts about a third of the time.
            if (n == count - 1)
                gap = 0;
            else if (with_idle && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 14);
            else
                gap = KEEP_START;
            send_target(tgt, gap);
        end
    endtask

    initial begin
        model_pll_hz    = PLL_RESET_HZ;
        model_held_word = '0;
        // Hold reset, then release it on an edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_band_edges();
        test_pll_extremes();
        test_random_targets(75, PLL_RESET_HZ, 1'b1);
        test_random_targets(75, $urandom, 1'b1);
        test_random_targets(75, $urandom_range(100000000, 1200000000), 1'b1);
        test_random_targets(50, 32'd0, 1'b1);
        test_random_targets(50, 32'hFFFFFFFF, 1'b1);
        test_random_targets(50, $urandom_range(1, 50000000), 1'b1);
        // Finish with back-to-back words and no idling at all.
        test_random_targets(75, $urandom_range(200000000, 800000000), 1'b0);

        // Drain what is still owed, then let the solver settle.
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("[sd_clock_divider_solver_top] OK");
        else
            $display("[sd_clock_divider_solver_top] ERROR");
        $finish;
    end

    // Watchdog: end the run with an error if it has not finished.
    initial begin
        #5000000;
        $display("[sd_clock_divider_solver_top] ERROR");
        $finish;
    end

endmodule
